>>> rtl/tsta_pkg.sv
// tsta_pkg: shared widths, register indexes and reset values
// used by the trapezoid segment time allocator top level
`timescale 1ns / 1ps
package tsta_pkg;
	localparam int COORD_W = 32;
	localparam int LIMIT_W = 32;
	localparam int DUR_W = 32;
	localparam int FRACTION_BITS_DEF = 16;

	typedef logic [0:0] reg_index_t;
	localparam reg_index_t REG_MAX_VELOCITY = 1'b0;
	localparam reg_index_t REG_MAX_ACCELERATION = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd196608;
endpackage

>>> rtl/tsta_mul.sv
// tsta_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// standalone, no package dependencies
`timescale 1ns / 1ps
module tsta_mul #(
	parameter int AW = 34,
	parameter int BW = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] p
);
	localparam int CW = $clog2(BW + 1);

	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [AW+BW-1:0] mcand_q;
	logic [BW-1:0]    mplier_q;
	logic [AW+BW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= (AW+BW)'(a);
			mplier_q <= b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign p = acc_q;
endmodule

>>> rtl/tsta_div.sv
// tsta_div: restoring divider, one quotient bit per cycle
// standalone, no package dependencies
`timescale 1ns / 1ps
module tsta_div #(
	parameter int NW = 84,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the freed low end of the numerator
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DW-1:0];
			end
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = num_q;
endmodule

>>> rtl/tsta_sqrt.sv
// tsta_sqrt: restoring integer square root, one root bit per cycle
// standalone, no package dependencies
`timescale 1ns / 1ps
module tsta_sqrt #(
	parameter int XW = 68
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [XW-1:0]   x,
	output logic            done,
	output logic [XW/2-1:0] root
);
	localparam int RW = XW / 2;
	localparam int CW = $clog2(RW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [XW-1:0] x_q;
	logic [RW:0]   rem_q;
	logic [RW-1:0] root_q;
	logic [RW+2:0] t;
	logic [RW+2:0] trial;
	logic          fits;

	assign t = {rem_q, x_q[XW-1:XW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(RW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			rem_q <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= (RW+1)'(t - trial);
			end else begin
				rem_q <= t[RW:0];
			end
			root_q <= {root_q[RW-2:0], fits};
			x_q <= x_q << 2;
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

>>> rtl/trapezoid_segment_time_allocator.sv
// trapezoid_segment_time_allocator: waypoint segment duration under velocity and
// acceleration limits; sequencer over tsta_mul, tsta_div and tsta_sqrt, uses tsta_pkg
// steps: three squaring multiplies and a root give the distance; a zero limit
// saturates the duration, else distance times acceleration and velocity squared
// follow, then a divide and a root if triangular, else a multiply and a divide;
// one waypoint at a time, the next taken once the result is in the output register;
// a route start or first waypoint yields no item; reset is asynchronous, active low
`timescale 1ns / 1ps
module trapezoid_segment_time_allocator #(
	parameter int FRACTION_BITS = tsta_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [3*tsta_pkg::COORD_W-1:0] s_tdata,  // waypoint_x, waypoint_y, waypoint_z
	input  logic                         s_tuser,   // route_start
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tsta_pkg::DUR_W-1:0]   m_tdata,   // segment_duration
	output logic [1:0]                   m_tuser,   // duration_saturated, triangular_profile
	input  logic                         cfg_we,
	input  tsta_pkg::reg_index_t         cfg_index,
	input  logic [tsta_pkg::LIMIT_W-1:0] cfg_data
);
	import tsta_pkg::*;

	localparam int DW = COORD_W + 1;
	localparam int MA_W = COORD_W + 2;
	localparam int MB_W = COORD_W + 1;
	localparam int MP_W = MA_W + MB_W;
	localparam int TRI_W = MA_W + 2 * FRACTION_BITS + 2;
	localparam int TRP_W = MP_W + FRACTION_BITS;
	localparam int DIV_W = (TRI_W > TRP_W) ? TRI_W : TRP_W;
	localparam int DEN_W = 2 * LIMIT_W;
	localparam int SQ_W = (TRI_W > 68) ? TRI_W : 68;
	localparam int RW = SQ_W / 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MX   = 4'd1;
	localparam logic [3:0] S_MY   = 4'd2;
	localparam logic [3:0] S_MZ   = 4'd3;
	localparam logic [3:0] S_SQ1  = 4'd4;
	localparam logic [3:0] S_MDA  = 4'd5;
	localparam logic [3:0] S_MVV  = 4'd6;
	localparam logic [3:0] S_DTRI = 4'd7;
	localparam logic [3:0] S_SQ2  = 4'd8;
	localparam logic [3:0] S_MAV  = 4'd9;
	localparam logic [3:0] S_DTRP = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0]         state_q;
	logic               kick_q;
	logic               have_prev_q;
	logic [LIMIT_W-1:0] vel_q;
	logic [LIMIT_W-1:0] acc_q;
	logic [COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [DW-1:0]      dx_q, dy_q, dz_q;
	logic [MP_W-1:0]    sum_q;
	logic [MA_W-1:0]    dist_q;
	logic [MP_W-1:0]    da_q;
	logic [MP_W-1:0]    vv_q;
	logic [DEN_W-1:0]   av_q;
	logic [DUR_W-1:0]   res_dur_q;
	logic               res_sat_q, res_tri_q;
	logic               out_valid_q;
	logic [DUR_W-1:0]   out_dur_q;
	logic               out_sat_q, out_tri_q;

	logic [COORD_W-1:0] in_x, in_y, in_z;
	logic [DW-1:0]      dx, dy, dz;
	logic               accept;

	logic               mul_start, mul_done;
	logic [MA_W-1:0]    mul_a;
	logic [MB_W-1:0]    mul_b;
	logic [MP_W-1:0]    mul_p;
	logic               div_start, div_done;
	logic [DIV_W-1:0]   div_num, div_quo;
	logic [DEN_W-1:0]   div_den;
	logic               sq_start, sq_done;
	logic [SQ_W-1:0]    sq_x;
	logic [RW-1:0]      sq_root;
	logic [MP_W-1:0]    vda;

	function automatic logic [DW-1:0] abs_diff(input logic [COORD_W-1:0] p,
			input logic [COORD_W-1:0] q);
		logic [DW-1:0] d;
		d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
		return d[DW-1] ? DW'(-d) : d;
	endfunction

	assign in_x = s_tdata[COORD_W-1:0];
	assign in_y = s_tdata[2*COORD_W-1:COORD_W];
	assign in_z = s_tdata[3*COORD_W-1:2*COORD_W];
	assign dx = abs_diff(in_x, prev_x_q);
	assign dy = abs_diff(in_y, prev_y_q);
	assign dz = abs_diff(in_z, prev_z_q);

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;

	assign mul_start = kick_q && (state_q == S_MX || state_q == S_MY || state_q == S_MZ ||
		state_q == S_MDA || state_q == S_MVV || state_q == S_MAV);
	assign div_start = kick_q && (state_q == S_DTRI || state_q == S_DTRP);
	assign sq_start = kick_q && (state_q == S_SQ1 || state_q == S_SQ2);

	always_comb begin
		case (state_q)
			S_MX: begin
				mul_a = MA_W'(dx_q);
				mul_b = dx_q;
			end
			S_MY: begin
				mul_a = MA_W'(dy_q);
				mul_b = dy_q;
			end
			S_MZ: begin
				mul_a = MA_W'(dz_q);
				mul_b = dz_q;
			end
			S_MDA: begin
				mul_a = dist_q;
				mul_b = MB_W'(acc_q);
			end
			S_MVV: begin
				mul_a = MA_W'(vel_q);
				mul_b = MB_W'(vel_q);
			end
			S_MAV: begin
				mul_a = MA_W'(acc_q);
				mul_b = MB_W'(vel_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign vda = vv_q + da_q;
	assign div_num = (state_q == S_DTRI) ?
		DIV_W'({dist_q, {(2*FRACTION_BITS+2){1'b0}}}) :
		DIV_W'({vda, {FRACTION_BITS{1'b0}}});
	assign div_den = (state_q == S_DTRI) ? DEN_W'(acc_q) : av_q;
	assign sq_x = (state_q == S_SQ1) ? SQ_W'(sum_q) : SQ_W'(div_quo[TRI_W-1:0]);

	tsta_mul #(.AW(MA_W), .BW(MB_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	tsta_div #(.NW(DIV_W), .DW(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	tsta_sqrt #(.XW(SQ_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.x(sq_x), .done(sq_done), .root(sq_root)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q <= LIMIT_RESET;
			acc_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_VELOCITY: vel_q <= cfg_data;
				REG_MAX_ACCELERATION: acc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kick_q <= 1'b0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			if (out_valid_q && m_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b1;
						if (have_prev_q && !s_tuser) begin
							state_q <= S_MX;
							kick_q <= 1'b1;
						end
					end
				end
				S_MX: if (mul_done) begin
					state_q <= S_MY;
					kick_q <= 1'b1;
				end
				S_MY: if (mul_done) begin
					state_q <= S_MZ;
					kick_q <= 1'b1;
				end
				S_MZ: if (mul_done) begin
					state_q <= S_SQ1;
					kick_q <= 1'b1;
				end
				S_SQ1: if (sq_done) begin
					if (vel_q == '0 || acc_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MDA;
						kick_q <= 1'b1;
					end
				end
				S_MDA: if (mul_done) begin
					state_q <= S_MVV;
					kick_q <= 1'b1;
				end
				S_MVV: if (mul_done) begin
					state_q <= (da_q < mul_p) ? S_DTRI : S_MAV;
					kick_q <= 1'b1;
				end
				S_DTRI: if (div_done) begin
					state_q <= S_SQ2;
					kick_q <= 1'b1;
				end
				S_SQ2: if (sq_done) begin
					state_q <= S_OUT;
				end
				S_MAV: if (mul_done) begin
					state_q <= S_DTRP;
					kick_q <= 1'b1;
				end
				S_DTRP: if (div_done) begin
					state_q <= S_OUT;
				end
				S_OUT: if (!out_valid_q || m_tready) begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			prev_z_q <= in_z;
			dx_q <= dx;
			dy_q <= dy;
			dz_q <= dz;
		end
		if (mul_done) begin
			case (state_q)
				S_MX: sum_q <= mul_p;
				S_MY, S_MZ: sum_q <= sum_q + mul_p;
				S_MDA: da_q <= mul_p;
				S_MVV: begin
					vv_q <= mul_p;
					res_tri_q <= (da_q < mul_p);
				end
				S_MAV: av_q <= mul_p[DEN_W-1:0];
				default: ;
			endcase
		end
		if (sq_done && state_q == S_SQ1) begin
			dist_q <= sq_root[MA_W-1:0];
			if (vel_q == '0 || acc_q == '0) begin
				res_dur_q <= '1;
				res_sat_q <= 1'b1;
				res_tri_q <= 1'b0;
			end
		end
		if (sq_done && state_q == S_SQ2) begin
			res_sat_q <= (sq_root[RW-1:DUR_W] != '0);
			res_dur_q <= (sq_root[RW-1:DUR_W] != '0) ? '1 : sq_root[DUR_W-1:0];
		end
		if (div_done && state_q == S_DTRP) begin
			res_sat_q <= (div_quo[DIV_W-1:DUR_W] != '0);
			res_dur_q <= (div_quo[DIV_W-1:DUR_W] != '0) ? '1 : div_quo[DUR_W-1:0];
		end
		if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
			out_dur_q <= res_dur_q;
			out_sat_q <= res_sat_q;
			out_tri_q <= res_tri_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_dur_q;
	assign m_tuser = {out_tri_q, out_sat_q};

`ifndef NO_ASSERTIONS
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MX || state_q == S_MY || state_q == S_MZ ||
			state_q == S_MDA || state_q == S_MVV || state_q == S_MAV))
		else $error("multiplier finished outside a multiply step");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DTRI || state_q == S_DTRP))
		else $error("divider finished outside a divide step");
	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '1))
		else $error("saturated item without full-scale duration");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("output item raised outside the output step");
`endif
endmodule
